// ===== sv/lpts_pkg.sv =====
// ----------------------------------------------------------------------------
// lpts_pkg
// Shared types and constants for the patience-sort tail search block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpts_pkg;

  // Width of the reported subsequence length
  localparam int unsigned RUN_LEN_W = 9;

  // Sequencer state codes
  localparam int unsigned STATE_W = 2;
  typedef logic [STATE_W-1:0] state_t;

  localparam state_t ST_IDLE   = 2'd0;
  localparam state_t ST_LAST   = 2'd1;
  localparam state_t ST_SEARCH = 2'd2;

endpackage : lpts_pkg

`default_nettype wire

// ===== sv/lpts_ram.sv =====
// ----------------------------------------------------------------------------
// lpts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : lpts_ram

`default_nettype wire

// ===== sv/lis_patience_tail_search_top.sv =====
// ----------------------------------------------------------------------------
// lis_patience_tail_search_top
// Longest strictly increasing subsequence length by patience-sort tail search.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, sample_value_i,   | sink
//          | start_new_i                               |
//  out     | out_valid_o, out_stall_i, run_length_o,   | source
//          | overflow_o                                |
//
// One item at a time. The result is registered on leaving ST_LAST for an append
// or for a replace of the only tail, and on leaving ST_SEARCH for any other
// replace, after a binary search with one tail-RAM read per step. The next beat
// is taken once the block is back in ST_IDLE, so each item is finished first.
// A new beat is taken even while the result is stalled; its steps then hold
// until that result leaves. Reset clears the length; tail RAM contents are not
// cleared and need no clearing pass since only entries below the length are read.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_patience_tail_search_top
  import lpts_pkg::*;
#(
  parameter int unsigned TAIL_DEPTH  = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [VALUE_WIDTH-1:0] sample_value_i,
  input  wire logic                          start_new_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic             [RUN_LEN_W-1:0]   run_length_o,
  output logic                               overflow_o
);

  localparam int unsigned AddrW = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TAIL_DEPTH + 1);

  state_t                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [AddrW-1:0]       lo_q, lo_d;
  logic [AddrW-1:0]       hi_q, hi_d;
  logic [AddrW-1:0]       mid_q, mid_d;
  logic                   out_valid_q, out_valid_d;
  logic [RUN_LEN_W-1:0]   run_q, run_d;
  logic                   ovf_q, ovf_d;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic                   ram_re;
  logic [AddrW-1:0]       ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic [VALUE_WIDTH-1:0] key_in;
  logic [CntW-1:0]        cnt_eff;
  logic                   out_busy;
  logic                   tail_lt;
  logic [AddrW-1:0]       hi_last;
  logic [AddrW-1:0]       s_lo, s_hi, s_mid;

  // Flip the sign bit so unsigned order matches signed order
  assign key_in = {~sample_value_i[VALUE_WIDTH-1], sample_value_i[VALUE_WIDTH-2:0]};

  assign cnt_eff  = start_new_i ? '0 : cnt_q;
  assign out_busy = out_valid_q && out_stall_i;
  assign tail_lt  = ram_rdata < key_q;
  assign hi_last  = AddrW'(cnt_q - CntW'(1));

  // One lower-bound step on the tail just read at mid
  assign s_lo  = tail_lt ? (mid_q + AddrW'(1)) : lo_q;
  assign s_hi  = tail_lt ? hi_q : mid_q;
  assign s_mid = s_lo + ((s_hi - s_lo) >> 1);

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    out_valid_d = out_busy;
    run_d       = run_q;
    ovf_d       = ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = key_in;
          cnt_d   = cnt_eff;
          state_d = ST_LAST;
          // Fetch the last tail when there is one
          if (cnt_eff != '0) begin
            ram_re    = 1'b1;
            ram_raddr = AddrW'(cnt_eff - CntW'(1));
          end
        end
      end

      ST_LAST: begin
        if (!out_busy) begin
          if (cnt_q == '0 || tail_lt) begin
            // Append, or drop when the store is full
            if (cnt_q < CntW'(TAIL_DEPTH)) begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[AddrW-1:0];
              cnt_d     = cnt_q + CntW'(1);
              ovf_d     = 1'b0;
            end else begin
              ovf_d = 1'b1;
            end
            run_d       = RUN_LEN_W'(cnt_d);
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else if (hi_last == '0) begin
            ram_we      = 1'b1;
            ram_waddr   = '0;
            ovf_d       = 1'b0;
            run_d       = RUN_LEN_W'(cnt_q);
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            // Search [0, count-1]; the last tail is known to be >= key
            lo_d      = '0;
            hi_d      = hi_last;
            mid_d     = hi_last >> 1;
            ram_re    = 1'b1;
            ram_raddr = hi_last >> 1;
            state_d   = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (!out_busy) begin
          if (s_lo < s_hi) begin
            lo_d      = s_lo;
            hi_d      = s_hi;
            mid_d     = s_mid;
            ram_re    = 1'b1;
            ram_raddr = s_mid;
          end else begin
            // Replace the first tail that is >= key
            ram_we      = 1'b1;
            ram_waddr   = s_lo;
            ovf_d       = 1'b0;
            run_d       = RUN_LEN_W'(cnt_q);
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    run_q <= run_d;
    ovf_q <= ovf_d;
  end

  lpts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TAIL_DEPTH)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign run_length_o = run_q;
  assign overflow_o   = ovf_q;

endmodule : lis_patience_tail_search_top

`default_nettype wire
